@@ hdl/sctc_pkg.sv @@
// Shared constants, control struct and calendar tables for the seconds-to-calendar converter.
`default_nettype none

package sctc_pkg;

    // Pipeline depth: input register through output register
    localparam int NUM_STAGES = 7;

    // Seconds per day is 2^7 * 675; divide the upper 25 bits by 675
    localparam int          DAY_SHIFT_IN  = 7;
    localparam int          DAY_RECIP_SH  = 35;
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;
    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;

    // Days in one four-year block, leap year third in each block
    localparam int          BLK_RECIP_SH  = 27;
    localparam logic [16:0] BLK_RECIP     = 17'd91868;
    localparam logic [10:0] DAYS_PER_BLK  = 11'd1461;
    localparam logic [10:0] BLK_Y1_START  = 11'd365;
    localparam logic [10:0] BLK_Y2_START  = 11'd730;
    localparam logic [10:0] BLK_Y3_START  = 11'd1096;
    localparam logic [11:0] FIRST_YEAR    = 12'd1970;

    // Seconds per hour is 2^4 * 225; divide the upper 13 bits by 225
    localparam int          HOUR_SHIFT_IN = 4;
    localparam int          HOUR_RECIP_SH = 21;
    localparam logic [13:0] HOUR_RECIP    = 14'd9321;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;

    // Seconds per minute is 2^2 * 15; divide the upper 10 bits by 15
    localparam int          MIN_SHIFT_IN  = 2;
    localparam int          MIN_RECIP_SH  = 14;
    localparam logic [10:0] MIN_RECIP     = 11'd1093;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;

    // Month codes
    localparam logic [3:0]  MONTH_JAN     = 4'd1;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;

    // Per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    // Zero-based day of year on which a month starts
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] month);
        logic [8:0] start;
        unique case (month)
            4'd1:    start = 9'd0;
            4'd2:    start = 9'd31;
            4'd3:    start = leap ? 9'd60  : 9'd59;
            4'd4:    start = leap ? 9'd91  : 9'd90;
            4'd5:    start = leap ? 9'd121 : 9'd120;
            4'd6:    start = leap ? 9'd152 : 9'd151;
            4'd7:    start = leap ? 9'd182 : 9'd181;
            4'd8:    start = leap ? 9'd213 : 9'd212;
            4'd9:    start = leap ? 9'd244 : 9'd243;
            4'd10:   start = leap ? 9'd274 : 9'd273;
            4'd11:   start = leap ? 9'd305 : 9'd304;
            4'd12:   start = leap ? 9'd335 : 9'd334;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

@@ hdl/seconds_to_calendar_datetime.sv @@
// The input register is the first of the seven pipeline stages and the output register
// the last of them.
// Throughput: one transaction per cycle while the output is not stalled; each stage holds one item
// and moves on its own load enable, so bubbles close up behind a stalled output.
// The stage count is set by the four reciprocal divides and their multiply-back steps.
// Reset (synchronous, active low) clears the valid bits; the datapath needs none.
`default_nettype none

module seconds_to_calendar_datetime
    import sctc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_epoch_seconds,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [11:0] o_year,
    output logic      [3:0]  o_month,
    output logic      [4:0]  o_day_of_month,
    output logic      [4:0]  o_hour,
    output logic      [5:0]  o_minute,
    output logic      [5:0]  o_second
);

    t_pipe_ctl   w_ctl;
    logic [15:0] w_days;
    logic [16:0] w_sec_of_day;

    // Valid bits and stage enables
    sctc_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctl   (w_ctl)
    );

    // Split into days and seconds of day
    sctc_day_split u_split (
        .i_clk           (i_clk),
        .i_ctl           (w_ctl),
        .i_epoch_seconds (i_epoch_seconds),
        .o_days          (w_days),
        .o_sec_of_day    (w_sec_of_day)
    );

    // Calendar date
    sctc_date u_date (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_days         (w_days),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month)
    );

    // Time of day
    sctc_tod u_tod (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_sec_of_day (w_sec_of_day),
        .o_hour       (o_hour),
        .o_minute     (o_minute),
        .o_second     (o_second)
    );

endmodule

`default_nettype wire

@@ hdl/sctc_pipe_ctrl.sv @@
// Valid bits and per-stage load enables for the converter pipeline.
`default_nettype none

module sctc_pipe_ctrl
    import sctc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_pipe_ctl      o_ctl
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_rdy;

    // A stage may load when it is empty or the stage after it moves
    always_comb begin
        n_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            n_rdy[k] = !r_vld[k] || n_rdy[k+1];
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ctl.en = n_rdy;
    assign o_stall  = !n_rdy[0];
    assign o_valid  = r_vld[NUM_STAGES-1];

endmodule

`default_nettype wire

@@ hdl/sctc_day_split.sv @@
// Input register and split of the seconds count into whole days and seconds of day.
`default_nettype none

module sctc_day_split
    import sctc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_pipe_ctl   i_ctl,
    input  wire logic [31:0] i_epoch_seconds,
    output logic      [15:0] o_days,
    output logic      [16:0] o_sec_of_day
);

    logic [31:0] r_secs0;
    logic [31:0] r_secs1;
    logic [15:0] r_days1;
    logic [15:0] r_days2;
    logic [16:0] r_sod2;
    logic [50:0] n_day_prod;
    logic [32:0] n_day_secs;
    logic [31:0] n_sod_full;

    // Capture the transaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_secs0 <= i_epoch_seconds;
        end
    end

    // Divide by seconds per day through the reciprocal
    assign n_day_prod = 51'(r_secs0[31:DAY_SHIFT_IN]) * 51'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_secs1 <= r_secs0;
            r_days1 <= n_day_prod[DAY_RECIP_SH +: 16];
        end
    end

    // Take back the whole days to leave the seconds of the day
    assign n_day_secs = 33'(r_days1) * 33'(SEC_PER_DAY);
    assign n_sod_full = r_secs1 - n_day_secs[31:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_days2 <= r_days1;
            r_sod2  <= n_sod_full[16:0];
        end
    end

    assign o_days       = r_days2;
    assign o_sec_of_day = r_sod2;

endmodule

`default_nettype wire

@@ hdl/sctc_date.sv @@
// Date path: whole days to year, month and day of month over four stages.
`default_nettype none

module sctc_date
    import sctc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_pipe_ctl   i_ctl,
    input  wire logic [15:0] i_days,
    output logic      [11:0] o_year,
    output logic      [3:0]  o_month,
    output logic      [4:0]  o_day_of_month
);

    logic [15:0] r_days3;
    logic [5:0]  r_blk3;
    logic [5:0]  r_blk4;
    logic [10:0] r_bday4;
    logic [11:0] r_year5;
    logic [8:0]  r_doy5;
    logic        r_leap5;
    logic [11:0] r_year6;
    logic [3:0]  r_month6;
    logic [4:0]  r_day6;

    logic [32:0] n_blk_prod;
    logic [16:0] n_blk_days;
    logic [15:0] n_bday_full;
    logic [1:0]  n_yoff;
    logic [10:0] n_doy_full;
    logic        n_leap;
    logic [11:0] n_year;
    logic [3:0]  n_month;
    logic [8:0]  n_day_full;

    // Divide by days per four-year block through the reciprocal
    assign n_blk_prod = 33'(i_days) * 33'(BLK_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_days3 <= i_days;
            r_blk3  <= n_blk_prod[BLK_RECIP_SH +: 6];
        end
    end

    // Day within the block
    assign n_blk_days  = 17'(r_blk3) * 17'(DAYS_PER_BLK);
    assign n_bday_full = r_days3 - n_blk_days[15:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_blk4  <= r_blk3;
            r_bday4 <= n_bday_full[10:0];
        end
    end

    // Pick the year of the block; the third one is the leap year
    always_comb begin
        n_leap = 1'b0;
        priority if (r_bday4 < BLK_Y1_START) begin
            n_yoff     = 2'd0;
            n_doy_full = r_bday4;
        end else if (r_bday4 < BLK_Y2_START) begin
            n_yoff     = 2'd1;
            n_doy_full = r_bday4 - BLK_Y1_START;
        end else if (r_bday4 < BLK_Y3_START) begin
            n_yoff     = 2'd2;
            n_doy_full = r_bday4 - BLK_Y2_START;
            n_leap     = 1'b1;
        end else begin
            n_yoff     = 2'd3;
            n_doy_full = r_bday4 - BLK_Y3_START;
        end
        n_year = FIRST_YEAR + {4'd0, r_blk4, 2'b00} + 12'(n_yoff);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r_year5 <= n_year;
            r_doy5  <= n_doy_full[8:0];
            r_leap5 <= n_leap;
        end
    end

    // Find the last month that starts on or before the day of year
    always_comb begin
        n_month = MONTH_JAN;
        for (int m = 2; m <= 12; m++) begin
            if (r_doy5 >= month_start(r_leap5, 4'(m))) begin
                n_month = 4'(m);
            end
        end
        n_day_full = r_doy5 - month_start(r_leap5, n_month) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            r_year6  <= r_year5;
            r_month6 <= n_month;
            r_day6   <= n_day_full[4:0];
        end
    end

    assign o_year         = r_year6;
    assign o_month        = r_month6;
    assign o_day_of_month = r_day6;

endmodule

`default_nettype wire

@@ hdl/sctc_tod.sv @@
// Time-of-day path: seconds of day to hour, minute and second over four stages.
`default_nettype none

module sctc_tod
    import sctc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_pipe_ctl   i_ctl,
    input  wire logic [16:0] i_sec_of_day,
    output logic      [4:0]  o_hour,
    output logic      [5:0]  o_minute,
    output logic      [5:0]  o_second
);

    logic [16:0] r_sod3;
    logic [4:0]  r_hour3;
    logic [11:0] r_soh4;
    logic [4:0]  r_hour4;
    logic [11:0] r_soh5;
    logic [4:0]  r_hour5;
    logic [5:0]  r_min5;
    logic [4:0]  r_hour6;
    logic [5:0]  r_min6;
    logic [5:0]  r_sec6;

    logic [26:0] n_hour_prod;
    logic [16:0] n_hour_secs;
    logic [16:0] n_soh_full;
    logic [20:0] n_min_prod;
    logic [11:0] n_min_secs;
    logic [11:0] n_sec_full;

    // Divide by seconds per hour through the reciprocal
    assign n_hour_prod = 27'(i_sec_of_day[16:HOUR_SHIFT_IN]) * 27'(HOUR_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_sod3  <= i_sec_of_day;
            r_hour3 <= n_hour_prod[HOUR_RECIP_SH +: 5];
        end
    end

    // Seconds within the hour
    assign n_hour_secs = 17'(r_hour3) * 17'(SEC_PER_HOUR);
    assign n_soh_full  = r_sod3 - n_hour_secs;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_soh4  <= n_soh_full[11:0];
            r_hour4 <= r_hour3;
        end
    end

    // Divide by seconds per minute through the reciprocal
    assign n_min_prod = 21'(r_soh4[11:MIN_SHIFT_IN]) * 21'(MIN_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r_soh5  <= r_soh4;
            r_hour5 <= r_hour4;
            r_min5  <= n_min_prod[MIN_RECIP_SH +: 6];
        end
    end

    // Seconds within the minute
    assign n_min_secs = 12'(r_min5) * 12'(SEC_PER_MIN);
    assign n_sec_full = r_soh5 - n_min_secs;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            r_hour6 <= r_hour5;
            r_min6  <= r_min5;
            r_sec6  <= n_sec_full[5:0];
        end
    end

    assign o_hour   = r_hour6;
    assign o_minute = r_min6;
    assign o_second = r_sec6;

endmodule

`default_nettype wire
